/* rtl/scr_pkg.sv */
// Shared types and constants of the slot chain record store.
// Used by the controller, the datapath and the top level.
package scr_pkg;

  localparam logic [7:0] SLOT_LAST = 8'hFE;
  localparam logic [7:0] SLOT_FREE = 8'hFF;

  localparam logic [2:0] CMD_FORMAT = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_LOCATE = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_LOAD   = 3'd4;
  localparam logic [2:0] CMD_FINISH = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_OPEN = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NO_REC   = 3'd3;
  localparam logic [2:0] ST_CORRUPT  = 3'd4;

  localparam logic [1:0] REG_MAX_SLOTS = 2'd0;
  localparam logic [1:0] REG_BASE      = 2'd1;
  localparam logic [1:0] REG_HEADER    = 2'd2;
  localparam logic [1:0] REG_RECORD    = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_FORMAT, OP_NOTOPEN, OP_FULL, OP_APP_EMPTY, OP_CORRUPT,
    OP_SCAN_EV, OP_FIN, OP_APP_LINK, OP_APP_TAIL, OP_FIND_INIT, OP_FR_STEP,
    OP_FR_EV, OP_NOREC, OP_LOC_HIT, OP_DEL_HIT, OP_DEL_NXT, OP_DEL_HEAD,
    OP_FP_STEP, OP_DEL_LINK, OP_DEL_FREE, OP_LOAD_SLOT, OP_MUL, OP_PACK
  } dp_op_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       open;
    logic       m_zero;
    logic       total_zero;
    logic       scan_end;
    logic       fr_f;
    logic       la_f;
    logic       fr_hit;
    logic       fr_stop;
    logic       ptr_ok;
    logic       cur_first;
    logic       nxt_last;
    logic       fp_hit;
    logic       fp_stop;
  } dp_stat_t;

endpackage

/* rtl/scr_if.sv */
// Channel interfaces of the slot chain record store: command items,
// result items and configuration writes. No dependencies.
interface scr_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [5:0] rec_index;
  logic [7:0] field_offset;
  logic [5:0] load_slot;
  logic [7:0] load_header;
  modport source (output valid, cmd, rec_index, field_offset, load_slot, load_header,
                  input ready);
  modport sink (input valid, cmd, rec_index, field_offset, load_slot, load_header,
                output ready);
endinterface

interface scr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [15:0] rec_address;
  logic [6:0]  record_count;
  logic        link_valid;
  logic [5:0]  link_slot;
  logic [7:0]  link_value;
  modport source (output valid, status, slot, rec_address, record_count, link_valid,
                  link_slot, link_value, input ready);
  modport sink (input valid, status, slot, rec_address, record_count, link_valid,
                link_slot, link_value, output ready);
endinterface

interface scr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/slot_chain_record_store.sv */
// Slot chain record store: one command item at a time, one result item each.
// Format, load, not-open and undefined-code results need no slot map walk;
// append walks the slot map slot by slot, and finish load likewise; locate
// follows the chain hop by hop; delete walks to the record and then again
// from the head to its predecessor.
// Every step of these walks reads through the single read port of the slot map.
// Depends on scr_pkg, scr_if, scr_ctrl and scr_dp.
module slot_chain_record_store #(
  parameter int SLOTS = 64
) (
  input logic       clk,
  input logic       rst,
  scr_req_if.sink   req,
  scr_rsp_if.source rsp,
  scr_cfg_if.sink   cfg
);
  import scr_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  scr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .op        (op)
  );

  scr_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg),
    .op   (op),
    .stat (stat)
  );

endmodule

/* rtl/scr_ctrl.sv */
// Command sequencer of the slot chain record store.
// Depends on scr_pkg for datapath operation codes and status flags.
module scr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  scr_pkg::dp_stat_t stat,
  output scr_pkg::dp_op_t   op
);
  import scr_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_DISP      = 17'h00002,
    S_SCAN_RD   = 17'h00004,
    S_SCAN_EV   = 17'h00008,
    S_SCAN_DONE = 17'h00010,
    S_APP_TAIL  = 17'h00020,
    S_FR_CHK    = 17'h00040,
    S_FR_EV     = 17'h00080,
    S_DEL_NXT   = 17'h00100,
    S_DEL_HEAD  = 17'h00200,
    S_FP_CHK    = 17'h00400,
    S_FP_EV     = 17'h00800,
    S_DEL_LINK  = 17'h01000,
    S_DEL_FREE  = 17'h02000,
    S_MUL       = 17'h04000,
    S_PACK      = 17'h08000,
    S_OUT       = 17'h10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_MUL;
        if (stat.cmd == CMD_FORMAT) begin
          op = OP_FORMAT;
        end else if ((stat.cmd == CMD_APPEND || stat.cmd == CMD_LOCATE ||
                      stat.cmd == CMD_DELETE) && !stat.open) begin
          op = OP_NOTOPEN;
        end else if (stat.cmd == CMD_APPEND) begin
          if (stat.m_zero) begin
            op = OP_FULL;
          end else if (stat.total_zero) begin
            op = OP_APP_EMPTY;
          end else begin
            state_next = S_SCAN_RD;
          end
        end else if (stat.cmd == CMD_LOCATE || stat.cmd == CMD_DELETE) begin
          op         = OP_FIND_INIT;
          state_next = S_FR_CHK;
        end else if (stat.cmd == CMD_LOAD) begin
          op = OP_LOAD_SLOT;
        end else if (stat.cmd == CMD_FINISH) begin
          state_next = stat.m_zero ? S_SCAN_DONE : S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        op         = OP_SCAN_EV;
        state_next = stat.scan_end ? S_SCAN_DONE : S_SCAN_RD;
      end
      S_SCAN_DONE: begin
        state_next = S_MUL;
        if (stat.cmd == CMD_FINISH) begin
          op = OP_FIN;
        end else if (!stat.fr_f) begin
          op = OP_FULL;
        end else if (!stat.la_f) begin
          op = OP_CORRUPT;
        end else begin
          op         = OP_APP_LINK;
          state_next = S_APP_TAIL;
        end
      end
      S_APP_TAIL: begin
        op         = OP_APP_TAIL;
        state_next = S_MUL;
      end
      S_FR_CHK: begin
        if (stat.fr_hit) begin
          if (!stat.ptr_ok) begin
            op         = OP_NOREC;
            state_next = S_MUL;
          end else if (stat.cmd == CMD_LOCATE) begin
            op         = OP_LOC_HIT;
            state_next = S_MUL;
          end else begin
            op         = OP_DEL_HIT;
            state_next = S_DEL_NXT;
          end
        end else if (stat.fr_stop) begin
          op         = OP_NOREC;
          state_next = S_MUL;
        end else begin
          op         = OP_FR_STEP;
          state_next = S_FR_EV;
        end
      end
      S_FR_EV: begin
        op         = OP_FR_EV;
        state_next = S_FR_CHK;
      end
      S_DEL_NXT: begin
        op         = OP_DEL_NXT;
        state_next = stat.cur_first ? S_DEL_HEAD : S_FP_CHK;
      end
      S_DEL_HEAD: begin
        op         = OP_DEL_HEAD;
        state_next = S_DEL_FREE;
      end
      S_FP_CHK: begin
        if (stat.ptr_ok) begin
          state_next = S_FP_EV;
        end else if (stat.nxt_last) begin
          state_next = S_DEL_FREE;
        end else begin
          op         = OP_CORRUPT;
          state_next = S_MUL;
        end
      end
      S_FP_EV: begin
        if (stat.fp_hit) begin
          state_next = S_DEL_LINK;
        end else if (stat.fp_stop) begin
          if (stat.nxt_last) begin
            state_next = S_DEL_FREE;
          end else begin
            op         = OP_CORRUPT;
            state_next = S_MUL;
          end
        end else begin
          op         = OP_FP_STEP;
          state_next = S_FP_CHK;
        end
      end
      S_DEL_LINK: begin
        op         = OP_DEL_LINK;
        state_next = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        op         = OP_DEL_FREE;
        state_next = S_MUL;
      end
      S_MUL: begin
        op         = OP_MUL;
        state_next = S_PACK;
      end
      S_PACK: begin
        op         = OP_PACK;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

/* rtl/scr_dp.sv */
// Datapath of the slot chain record store: slot map memory, chain registers,
// configuration registers and result registers. Depends on scr_pkg, scr_if.
module scr_dp #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  scr_req_if.sink           req,
  scr_rsp_if.source         rsp,
  scr_cfg_if.sink           cfg,
  input  scr_pkg::dp_op_t   op,
  output scr_pkg::dp_stat_t stat
);
  import scr_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [7:0] NSLOTS = 8'(SLOTS);

  logic [7:0]  mem [SLOTS];
  logic [SLOTS-1:0] vld;
  logic [7:0]  rdata;
  logic        rvld;
  logic [7:0]  val;

  logic [6:0]  max_slots;
  logic [15:0] base_address;
  logic [11:0] header_bytes;
  logic [7:0]  record_bytes;

  logic [7:0]  first;
  logic [6:0]  total;
  logic        open;

  logic [2:0]  cmd_q;
  logic [5:0]  idx_q;
  logic [7:0]  off_q;
  logic [5:0]  ls_q;
  logic [7:0]  lh_q;

  logic [7:0]  ptr;
  logic [6:0]  cnt;
  logic [1:0]  lasts;
  logic [7:0]  fr;
  logic [7:0]  la;
  logic        fr_f;
  logic        la_f;
  logic [7:0]  cur;
  logic [7:0]  nxt;

  logic [2:0]  st;
  logic [7:0]  rslot;
  logic        lnk_v;
  logic [7:0]  lnk_s;
  logic [7:0]  lnk_val;
  logic        aen;
  logic        oen;
  logic [16:0] prod;

  logic [7:0]  m;
  logic [7:0]  cnt_inc;
  logic        ls_ok;
  logic        we;
  logic [7:0]  wa;
  logic [7:0]  wd;
  logic [6:0]  total_inc;
  logic [6:0]  total_dec;
  logic [15:0] addr_sum;

  assign m = ({1'b0, max_slots} < NSLOTS) ? {1'b0, max_slots} : NSLOTS;
  assign val = rvld ? rdata : SLOT_FREE;
  assign cnt_inc = {1'b0, cnt} + 8'd1;
  assign ls_ok = ({2'b00, ls_q} < m);
  assign total_inc = (total < 7'd127) ? total + 7'd1 : total;
  assign total_dec = (total > 7'd0) ? total - 7'd1 : total;
  assign addr_sum = base_address + 16'(header_bytes) + prod[15:0] + 16'd1 +
                    (oen ? 16'(off_q) : 16'd0);

  assign cfg.ready = 1'b1;

  always_comb begin
    stat.cmd        = cmd_q;
    stat.open       = open;
    stat.m_zero     = (m == 8'd0);
    stat.total_zero = (total == 7'd0);
    stat.scan_end   = ((ptr + 8'd1) >= m);
    stat.fr_f       = fr_f;
    stat.la_f       = la_f;
    stat.fr_hit     = (idx_q == 6'd0) || ({1'b0, idx_q} == cnt);
    stat.ptr_ok     = (ptr < m);
    stat.fr_stop    = (ptr >= m) || (cnt_inc >= m);
    stat.cur_first  = (cur == first);
    stat.nxt_last   = (nxt == SLOT_LAST);
    stat.fp_hit     = (val == cur);
    stat.fp_stop    = (cnt_inc >= m) || (val == SLOT_FREE);
  end

  always_comb begin
    we = 1'b0;
    wa = 8'd0;
    wd = SLOT_FREE;
    unique case (op)
      OP_APP_EMPTY: begin
        we = 1'b1;
        wa = 8'd0;
        wd = SLOT_LAST;
      end
      OP_APP_LINK: begin
        we = 1'b1;
        wa = la;
        wd = fr;
      end
      OP_APP_TAIL: begin
        we = 1'b1;
        wa = fr;
        wd = SLOT_LAST;
      end
      OP_DEL_LINK: begin
        we = 1'b1;
        wa = ptr;
        wd = nxt;
      end
      OP_DEL_FREE: begin
        we = 1'b1;
        wa = cur;
        wd = SLOT_FREE;
      end
      OP_LOAD_SLOT: begin
        we = ls_ok;
        wa = {2'b00, ls_q};
        wd = lh_q;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa[AW-1:0]] <= wd;
    end
    rdata <= mem[ptr[AW-1:0]];
    rvld  <= (ptr < NSLOTS) && vld[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_slots    <= 7'd64;
      base_address <= 16'd0;
      header_bytes <= 12'd16;
      record_bytes <= 8'd16;
      first        <= SLOT_FREE;
      total        <= 7'd0;
      open         <= 1'b0;
      vld          <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MAX_SLOTS: max_slots    <= cfg.data[6:0];
          REG_BASE:      base_address <= cfg.data;
          REG_HEADER:    header_bytes <= cfg.data[11:0];
          REG_RECORD:    record_bytes <= cfg.data[7:0];
          default:       max_slots    <= max_slots;
        endcase
      end
      unique case (op)
        OP_FORMAT: begin
          first <= SLOT_FREE;
          total <= 7'd0;
          open  <= 1'b1;
          vld   <= '0;
        end
        OP_APP_EMPTY: begin
          first <= 8'd0;
          total <= total_inc;
        end
        OP_APP_TAIL:  total <= total_inc;
        OP_DEL_HEAD:  first <= nxt;
        OP_DEL_FREE:  total <= total_dec;
        OP_LOAD_SLOT: open  <= 1'b0;
        OP_FIN: begin
          total <= cnt;
          open  <= 1'b1;
        end
        default: open <= open;
      endcase
      if (we) begin
        vld[wa[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        cmd_q   <= req.cmd;
        idx_q   <= req.rec_index;
        off_q   <= req.field_offset;
        ls_q    <= req.load_slot;
        lh_q    <= req.load_header;
        st      <= ST_OK;
        rslot   <= 8'd0;
        lnk_v   <= 1'b0;
        lnk_s   <= 8'd0;
        lnk_val <= 8'd0;
        aen     <= 1'b0;
        oen     <= 1'b0;
        ptr     <= 8'd0;
        cnt     <= 7'd0;
        lasts   <= 2'd0;
        fr_f    <= 1'b0;
        la_f    <= 1'b0;
      end
      OP_NOTOPEN:   st <= ST_NOT_OPEN;
      OP_FULL:      st <= ST_FULL;
      OP_CORRUPT:   st <= ST_CORRUPT;
      OP_NOREC:     st <= ST_NO_REC;
      OP_APP_EMPTY: aen <= 1'b1;
      OP_SCAN_EV: begin
        if (val != SLOT_FREE) begin
          cnt <= cnt + 7'd1;
        end
        if (val == SLOT_LAST && lasts != 2'd2) begin
          lasts <= lasts + 2'd1;
        end
        if (!fr_f && val == SLOT_FREE) begin
          fr   <= ptr;
          fr_f <= 1'b1;
        end
        if (!la_f && val == SLOT_LAST) begin
          la   <= ptr;
          la_f <= 1'b1;
        end
        ptr <= ptr + 8'd1;
      end
      OP_FIN: begin
        st <= (first == SLOT_FREE || lasts != 2'd1) ? ST_CORRUPT : ST_OK;
      end
      OP_APP_LINK: begin
        lnk_v   <= 1'b1;
        lnk_s   <= la;
        lnk_val <= fr;
      end
      OP_APP_TAIL: begin
        rslot <= fr;
        aen   <= 1'b1;
      end
      OP_FIND_INIT: begin
        ptr <= first;
        cnt <= 7'd0;
      end
      OP_FR_STEP: cnt <= cnt + 7'd1;
      OP_FR_EV:   ptr <= val;
      OP_LOC_HIT: begin
        rslot <= ptr;
        aen   <= 1'b1;
        oen   <= 1'b1;
      end
      OP_DEL_HIT: cur <= ptr;
      OP_DEL_NXT: begin
        nxt <= val;
        ptr <= first;
        cnt <= 7'd0;
      end
      OP_FP_STEP: begin
        ptr <= val;
        cnt <= cnt + 7'd1;
      end
      OP_DEL_LINK: begin
        lnk_v   <= 1'b1;
        lnk_s   <= ptr;
        lnk_val <= nxt;
      end
      OP_DEL_FREE: begin
        rslot <= cur;
        aen   <= 1'b1;
      end
      OP_LOAD_SLOT: rslot <= {2'b00, ls_q};
      OP_MUL: prod <= 17'(rslot) * 17'({1'b0, record_bytes} + 9'd1);
      OP_PACK: begin
        rsp.status       <= st;
        rsp.slot         <= rslot[5:0];
        rsp.rec_address  <= aen ? addr_sum : 16'd0;
        rsp.record_count <= total;
        rsp.link_valid   <= lnk_v;
        rsp.link_slot    <= lnk_s[5:0];
        rsp.link_value   <= lnk_val;
      end
      default: ptr <= ptr;
    endcase
  end

endmodule

/* sim/scr_checker.sv */
`timescale 1ns / 1ps
// Checker of the slot chain record store: watches the command, result and
// register write channels, predicts each result item and compares it.
// Depends on scr_pkg and the channel interfaces of scr_if.
module scr_checker (
  input  logic  clk,
  input  logic  rst,
  scr_req_if    req,
  scr_rsp_if    rsp,
  scr_cfg_if    cfg,
  output int    fail_count,
  output int    pending
);
  import scr_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [15:0] rec_address;
    logic [6:0]  record_count;
    logic        link_valid;
    logic [5:0]  link_slot;
    logic [7:0]  link_value;
  } result_t;

  localparam int NSLOT = 64;

  logic [7:0] slot_map [NSLOT];
  logic [7:0] head_slot;
  logic [6:0] rec_total;
  logic       is_open;
  logic [6:0] max_slots;
  logic [15:0] base_addr;
  logic [11:0] hdr_bytes;
  logic [7:0] rec_bytes;

  result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic int slot_limit();
    return (max_slots < NSLOT) ? int'(max_slots) : NSLOT;
  endfunction

  function automatic logic [15:0] byte_addr(int s, int off);
    int a;
    a = int'(base_addr) + int'(hdr_bytes) + s * (int'(rec_bytes) + 1) + 1 + off;
    return a[15:0];
  endfunction

  function automatic int walk_to(int idx);
    int m, s, r, i;
    m = slot_limit();
    s = head_slot;
    r = -1;
    i = 0;
    if (idx == 0) begin
      r = s;
    end else begin
      while (s != SLOT_LAST) begin
        if (i == idx) begin
          r = s;
          break;
        end
        i++;
        if (i >= m || s == SLOT_FREE || s >= m) break;
        s = slot_map[s];
      end
    end
    if (r < 0 || r >= m) return -1;
    return r;
  endfunction

  function automatic int walk_to_pred(int target);
    int m, p, c, i;
    m = slot_limit();
    p = head_slot;
    i = 0;
    while (p != SLOT_LAST) begin
      if (p >= m) break;
      c = slot_map[p];
      if (c == target) return p;
      p = c;
      i++;
      if (i >= m || c == SLOT_FREE) break;
    end
    return -1;
  endfunction

  function automatic result_t run_command(logic [2:0] cmd, logic [5:0] idx,
                                          logic [7:0] off, logic [5:0] ls,
                                          logic [7:0] lh);
    result_t r;
    int m, fr, la, s, nxt, p, cnt, lasts;
    bit done;
    r = '0;
    m = slot_limit();
    if (cmd == CMD_FORMAT) begin
      foreach (slot_map[i]) slot_map[i] = SLOT_FREE;
      head_slot = SLOT_FREE;
      rec_total = 0;
      is_open = 1'b1;
    end else if (cmd >= CMD_APPEND && cmd <= CMD_DELETE && !is_open) begin
      r.status = ST_NOT_OPEN;
    end else if (cmd == CMD_APPEND) begin
      if (m == 0) begin
        r.status = ST_FULL;
      end else if (rec_total == 0) begin
        head_slot = 0;
        slot_map[0] = SLOT_LAST;
        if (rec_total < 127) rec_total++;
        r.rec_address = byte_addr(0, 0);
      end else begin
        fr = -1;
        la = -1;
        for (int i = 0; i < m; i++)
          if (fr < 0 && slot_map[i] == SLOT_FREE) fr = i;
        for (int i = 0; i < m; i++)
          if (la < 0 && slot_map[i] == SLOT_LAST) la = i;
        if (fr < 0) begin
          r.status = ST_FULL;
        end else if (la < 0) begin
          r.status = ST_CORRUPT;
        end else begin
          slot_map[la] = fr[7:0];
          slot_map[fr] = SLOT_LAST;
          if (rec_total < 127) rec_total++;
          r.slot = fr[5:0];
          r.rec_address = byte_addr(fr, 0);
          r.link_valid = 1'b1;
          r.link_slot = la[5:0];
          r.link_value = fr[7:0];
        end
      end
    end else if (cmd == CMD_LOCATE) begin
      s = walk_to(idx);
      if (s < 0) begin
        r.status = ST_NO_REC;
      end else begin
        r.slot = s[5:0];
        r.rec_address = byte_addr(s, off);
      end
    end else if (cmd == CMD_DELETE) begin
      s = walk_to(idx);
      if (s < 0) begin
        r.status = ST_NO_REC;
      end else begin
        nxt = slot_map[s];
        done = 1'b1;
        if (s == head_slot) begin
          head_slot = nxt[7:0];
        end else begin
          p = walk_to_pred(s);
          if (nxt == SLOT_LAST) begin
            if (p >= 0) begin
              slot_map[p] = SLOT_LAST;
              r.link_valid = 1'b1;
              r.link_slot = p[5:0];
              r.link_value = SLOT_LAST;
            end
          end else if (p < 0) begin
            done = 1'b0;
          end else begin
            slot_map[p] = nxt[7:0];
            r.link_valid = 1'b1;
            r.link_slot = p[5:0];
            r.link_value = nxt[7:0];
          end
        end
        if (done) begin
          slot_map[s] = SLOT_FREE;
          if (rec_total > 0) rec_total--;
          r.slot = s[5:0];
          r.rec_address = byte_addr(s, 0);
        end else begin
          r.status = ST_CORRUPT;
        end
      end
    end else if (cmd == CMD_LOAD) begin
      is_open = 1'b0;
      if (ls < m) slot_map[ls] = lh;
      r.slot = ls;
    end else if (cmd == CMD_FINISH) begin
      cnt = 0;
      lasts = 0;
      for (int i = 0; i < m; i++) begin
        if (slot_map[i] != SLOT_FREE) cnt++;
        if (slot_map[i] == SLOT_LAST) lasts++;
      end
      rec_total = (cnt > 127) ? 7'd127 : cnt[6:0];
      is_open = 1'b1;
      if (head_slot == SLOT_FREE || lasts != 1) r.status = ST_CORRUPT;
    end
    r.record_count = rec_total;
    return r;
  endfunction

  task automatic report(string field, int exp_val, int got_val);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, exp_val,
             got_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      foreach (slot_map[i]) slot_map[i] = SLOT_FREE;
      head_slot = SLOT_FREE;
      rec_total = 0;
      is_open = 1'b0;
      max_slots = 7'd64;
      base_addr = 16'd0;
      hdr_bytes = 12'd16;
      rec_bytes = 8'd16;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MAX_SLOTS: max_slots = cfg.data[6:0];
          REG_BASE:      base_addr = cfg.data;
          REG_HEADER:    hdr_bytes = cfg.data[11:0];
          REG_RECORD:    rec_bytes = cfg.data[7:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result item with none expected", $realtime);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (rsp.status !== e.status) report("status", e.status, rsp.status);
          if (rsp.slot !== e.slot) report("slot", e.slot, rsp.slot);
          if (rsp.rec_address !== e.rec_address)
            report("rec_address", e.rec_address, rsp.rec_address);
          if (rsp.record_count !== e.record_count)
            report("record_count", e.record_count, rsp.record_count);
          if (rsp.link_valid !== e.link_valid)
            report("link_valid", e.link_valid, rsp.link_valid);
          if (rsp.link_slot !== e.link_slot) report("link_slot", e.link_slot, rsp.link_slot);
          if (rsp.link_value !== e.link_value)
            report("link_value", e.link_value, rsp.link_value);
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(run_command(req.cmd, req.rec_index, req.field_offset,
                                               req.load_slot, req.load_header));
    end
  end

endmodule

/* sim/slot_chain_record_store_test.sv */
`timescale 1ns / 1ps
// Testbench top of the slot chain record store: clock, reset, command and
// register write stimulus, result back-pressure, watchdog and verdict.
// Depends on scr_pkg, scr_if, the block and scr_checker.
module slot_chain_record_store_test;
  import scr_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int STALL_LIMIT  = 20000;
  localparam int SETTLE       = 300;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent;
  int   idle_cycles;
  bit   quiet;
  int   rsp_stall;

  scr_req_if req_ch ();
  scr_rsp_if rsp_ch ();
  scr_cfg_if cfg_ch ();

  slot_chain_record_store u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  scr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int gap_len();
    if (quiet) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 50);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall <= 0;
    end else if (quiet) begin
      rsp_ch.ready <= 1'b1;
    end else if (rsp_stall > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rsp_stall <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send(logic [2:0] cmd, logic [5:0] idx, logic [7:0] off,
                      logic [5:0] ls, logic [7:0] lh);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.rec_index <= idx;
    req_ch.field_offset <= off;
    req_ch.load_slot <= ls;
    req_ch.load_header <= lh;
    forever begin
      @(negedge clk);
      if (req_ch.ready) break;
    end
    @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    forever begin
      @(negedge clk);
      if (cfg_ch.ready) break;
    end
    @(posedge clk);
  endtask

  task automatic set_regs(int ms, int ba, int hb, int rb);
    drain();
    write_reg(REG_MAX_SLOTS, ms[15:0]);
    write_reg(REG_BASE, ba[15:0]);
    write_reg(REG_HEADER, hb[15:0]);
    write_reg(REG_RECORD, rb[15:0]);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_cmd(int lim);
    int  w;
    logic [5:0] idx;
    w = $urandom_range(0, 99);
    idx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 8));
    if (w < 35) send(CMD_APPEND, 6'($urandom), 8'($urandom), 6'($urandom), 8'($urandom));
    else if (w < 60) send(CMD_LOCATE, idx, 8'($urandom), 6'($urandom), 8'($urandom));
    else if (w < 85) send(CMD_DELETE, idx, 8'($urandom), 6'($urandom), 8'($urandom));
    else if (w < 91) send(CMD_LOAD, idx, 8'($urandom),
                          6'($urandom_range(0, lim > 0 ? lim - 1 : 0)), 8'($urandom));
    else if (w < 95) send(CMD_FINISH, idx, 8'($urandom), 6'($urandom), 8'($urandom));
    else if (w < 97) send(CMD_FORMAT, idx, 8'($urandom), 6'($urandom), 8'($urandom));
    else send(3'($urandom_range(6, 7)), idx, 8'($urandom), 6'($urandom), 8'($urandom));
  endtask

  task automatic load_chain(int lim);
    int order [64];
    int k, j, t;
    bit broken;
    for (int i = 0; i < 64; i++) order[i] = i;
    k = $urandom_range(1, lim);
    for (int i = k - 1; i > 1; i--) begin
      j = $urandom_range(1, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    broken = ($urandom_range(0, 4) == 0);
    send(CMD_FORMAT, 0, 0, 0, 0);
    send(CMD_APPEND, 0, 0, 0, 0);
    for (int i = 0; i < lim; i++)
      send(CMD_LOAD, 0, 0, i[5:0], SLOT_FREE);
    for (int i = 0; i < k; i++)
      send(CMD_LOAD, 0, 0, order[i][5:0], (i == k - 1) ? SLOT_LAST : order[i + 1][7:0]);
    if (broken) send(CMD_LOAD, 0, 0, 6'($urandom_range(0, lim - 1)), 8'($urandom));
    send(CMD_FINISH, 0, 0, 0, 0);
  endtask

  initial begin
    int ms, lim, n;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= '0;
    req_ch.rec_index <= '0;
    req_ch.field_offset <= '0;
    req_ch.load_slot <= '0;
    req_ch.load_header <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    quiet = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(CMD_APPEND, 0, 0, 0, 0);
    send(CMD_LOCATE, 0, 8'hFF, 0, 0);
    send(CMD_DELETE, 0, 0, 0, 0);
    send(3'd6, 6'h3F, 8'hFF, 6'h3F, 8'hFF);
    send(3'd7, 0, 0, 0, 0);
    send(CMD_FORMAT, 0, 0, 0, 0);
    send(CMD_LOCATE, 0, 0, 0, 0);
    send(CMD_APPEND, 0, 0, 0, 0);
    send(CMD_APPEND, 0, 0, 0, 0);
    send(CMD_APPEND, 0, 0, 0, 0);
    send(CMD_LOCATE, 2, 8'hFF, 0, 0);
    send(CMD_LOCATE, 6'h3F, 0, 0, 0);
    send(CMD_DELETE, 1, 0, 0, 0);
    send(CMD_DELETE, 1, 0, 0, 0);
    send(CMD_DELETE, 0, 0, 0, 0);
    send(CMD_DELETE, 0, 0, 0, 0);
    send(CMD_LOAD, 0, 0, 6'h3F, SLOT_LAST);
    send(CMD_FINISH, 0, 0, 0, 0);
    send(CMD_APPEND, 0, 0, 0, 0);
    set_regs(1, 16'hFFFF, 4095, 255);
    send(CMD_FORMAT, 0, 0, 0, 0);
    send(CMD_APPEND, 0, 0, 0, 0);
    send(CMD_APPEND, 0, 0, 0, 0);
    send(CMD_LOCATE, 0, 8'hFF, 0, 0);
    set_regs(0, 0, 0, 1);
    send(CMD_APPEND, 0, 0, 0, 0);
    send(CMD_LOAD, 0, 0, 0, 0);

    n = sent;
    while (sent < n + RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: ms = 64;
        1: ms = 1;
        2: ms = 127;
        3: ms = 0;
        default: ms = $urandom_range(2, 64);
      endcase
      lim = (ms < 64) ? ms : 64;
      quiet = ($urandom_range(0, 4) == 0);
      set_regs(ms, $urandom_range(0, 1) ? 16'($urandom) : 16'hFFF0,
               $urandom_range(0, 4095), $urandom_range(1, 255));
      if (lim > 0 && lim <= 16 && $urandom_range(0, 2) == 0) load_chain(lim);
      else send(CMD_FORMAT, 0, 0, 0, 0);
      repeat ($urandom_range(20, 120)) random_cmd(lim);
    end

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/scr_pkg.sv
rtl/scr_if.sv
rtl/scr_ctrl.sv
rtl/scr_dp.sv
rtl/slot_chain_record_store.sv
sim/scr_checker.sv
sim/slot_chain_record_store_test.sv
